/* src/luhn_card_classifier_assert.svh */
// Assertion macros for the card classifier.
// Used by luhn_card_classifier.sv; expects clk_i and rst_ni in scope.
`ifndef LUHN_CARD_CLASSIFIER_ASSERT_SVH
`define LUHN_CARD_CLASSIFIER_ASSERT_SVH

// same-cycle implication
`define LCC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lcc assertion failed");

// next-cycle implication
`define LCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lcc assertion failed");

`endif

/* src/lcc_pkg.sv */
// Shared types, constants and helper functions for the card classifier.
// No dependencies.
package lcc_pkg;

  localparam int CardW       = 63;
  localparam int BitsPerStep = 4;
  localparam int ConvBits    = 56;                     // 10^16 < 2^54, padded
  localparam int ConvSteps   = ConvBits / BitsPerStep; // 14
  localparam int NumDigits   = 16;
  localparam int BcdW        = NumDigits * 4;
  localparam int LuhnSteps   = NumDigits / 2;          // one digit pair per cycle
  localparam int CntW        = 4;
  localparam int ClassW      = 2;

  localparam logic [CardW-1:0] Pow16 = 63'd10000000000000000;

  localparam logic [ClassW-1:0] CLASS_INVALID = 2'd0;
  localparam logic [ClassW-1:0] CLASS_MC      = 2'd1;
  localparam logic [ClassW-1:0] CLASS_AMEX    = 2'd2;
  localparam logic [ClassW-1:0] CLASS_VISA    = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_LUHN,
    ST_FIN
  } state_e;

  // one double-dabble bit step over all digits
  function automatic logic [BcdW-1:0] dabble(input logic [BcdW-1:0] b, input logic bit_in);
    logic [BcdW-1:0] c;
    c = b;
    for (int i = 0; i < NumDigits; i++) begin
      if (c[4*i +: 4] >= 4'd5) begin
        c[4*i +: 4] = c[4*i +: 4] + 4'd3;
      end
    end
    return {c[BcdW-2:0], bit_in};
  endfunction

  // doubled digit with its decimal digits summed
  function automatic logic [3:0] dbl_digit(input logic [3:0] d);
    logic [4:0] t;
    t = {d, 1'b0};
    return (t >= 5'd10) ? 4'(t - 5'd9) : t[3:0];
  endfunction

  // (acc + a + b) mod 10, all operands below 10
  function automatic logic [3:0] add_mod10(input logic [3:0] acc, input logic [3:0] a,
                                          input logic [3:0] b);
    logic [4:0] s;
    s = 5'(acc) + 5'(a) + 5'(b);
    if (s >= 5'd20) begin
      s = s - 5'd20;
    end else if (s >= 5'd10) begin
      s = s - 5'd10;
    end
    return s[3:0];
  endfunction

endpackage

/* src/luhn_card_classifier.sv */
// Card number classifier: length, Luhn mod-10 check and brand from leading digits.
// Depends on lcc_pkg and luhn_card_classifier_assert.svh.
//
// Usage:
//   Slave stream (s_axis_*) takes one card number per word: tdata[62:0] is the
//   number as an unsigned binary integer, tdata[63] is ignored. Master stream
//   (m_axis_*) returns one class word per card: tdata[1:0] = 0 invalid,
//   1 mastercard, 2 amex, 3 visa; tdata[7:2] are zero.
//   One card is worked on at a time; the next word is taken only once the
//   sequencer is back in idle. The work is binary to BCD conversion
//   (add-3/shift steps over all digits, four bits per cycle), then
//   Luhn summing (one digit pair per cycle through a mod-10 adder), then the
//   FIN state loads the output register. s_axis_tready_o is high only while idle.
//   Values of 10^16 and above are flagged at accept and end as invalid.
//   The output register is separate from the sequencer: a new card is taken
//   while the previous class still waits. If the receiver stalls, the
//   sequencer holds its finished result until the output register frees up.
//   Reset (rst_ni low, async) empties the sequencer and the output register.
module luhn_card_classifier
  import lcc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // [62:0] card_value, [63] pad
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o    // [1:0] card_class, [7:2] pad
);

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic [ConvBits-1:0] conv_q, conv_d;   // binary bits still to feed, MSB first
  logic [BcdW-1:0]     bcd_q, bcd_d;     // BCD digits, digit 0 in the low nibble
  logic [3:0]          sum_q, sum_d;     // Luhn total mod 10
  logic                too_long_q, too_long_d;
  logic                len_ok_q, len_ok_d;
  logic [ClassW-1:0]   cls_q, cls_d;

  logic              out_valid_q;
  logic [ClassW-1:0] out_class_q;

  logic in_acc;
  logic out_load;
  logic conv_last;
  logic luhn_last;

  // leading-digit decode
  logic [3:0] dig15, dig14, dig13, dig12, dig11;
  logic       n16, n15, n13;
  logic [3:0] hi_dig, lo_dig;
  logic [ClassW-1:0] lead_cls;

  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign conv_last = (cnt_q == CntW'(ConvSteps - 1));
  assign luhn_last = (cnt_q == CntW'(LuhnSteps - 1));

  // ---------------- sequencer: next state ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_CONV;
      end
      ST_CONV: begin
        if (conv_last) state_d = ST_LUHN;
      end
      ST_LUHN: begin
        if (luhn_last) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || m_axis_tready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------- sequencer: outputs ----------------
  always_comb begin
    s_axis_tready_o = 1'b0;
    out_load        = 1'b0;
    unique case (state_q)
      ST_IDLE: s_axis_tready_o = 1'b1;
      ST_CONV: ;
      ST_LUHN: ;
      ST_FIN:  out_load = !out_valid_q || m_axis_tready_i;
      default: ;
    endcase
  end

  // ---------------- leading digits and length ----------------
  always_comb begin
    dig15 = bcd_q[60 +: 4];
    dig14 = bcd_q[56 +: 4];
    dig13 = bcd_q[52 +: 4];
    dig12 = bcd_q[48 +: 4];
    dig11 = bcd_q[44 +: 4];
    n16   = (dig15 != 4'd0);
    n15   = (dig15 == 4'd0) && (dig14 != 4'd0);
    n13   = (dig15 == 4'd0) && (dig14 == 4'd0) && (dig13 == 4'd0) && (dig12 != 4'd0);
    if (n16) begin
      hi_dig = dig15;
      lo_dig = dig14;
    end else if (n15) begin
      hi_dig = dig14;
      lo_dig = dig13;
    end else begin
      hi_dig = dig12;
      lo_dig = dig11;
    end
    if (hi_dig == 4'd5 && lo_dig >= 4'd1 && lo_dig <= 4'd5) begin
      lead_cls = CLASS_MC;
    end else if (hi_dig == 4'd3 && (lo_dig == 4'd4 || lo_dig == 4'd7)) begin
      lead_cls = CLASS_AMEX;
    end else if (hi_dig == 4'd4) begin
      lead_cls = CLASS_VISA;
    end else begin
      lead_cls = CLASS_INVALID;
    end
  end

  // ---------------- datapath next values ----------------
  always_comb begin
    cnt_d      = cnt_q;
    conv_d     = conv_q;
    bcd_d      = bcd_q;
    sum_d      = sum_q;
    too_long_d = too_long_q;
    len_ok_d   = len_ok_q;
    cls_d      = cls_q;
    case (state_q)
      ST_IDLE: begin
        cnt_d      = '0;
        conv_d     = ConvBits'(s_axis_tdata_i[ConvBits-3:0]);
        bcd_d      = '0;
        sum_d      = 4'd0;
        too_long_d = (s_axis_tdata_i[CardW-1:0] >= Pow16);
      end
      ST_CONV: begin
        for (int k = 0; k < BitsPerStep; k++) begin
          bcd_d = dabble(bcd_d, conv_d[ConvBits-1]);
          conv_d = {conv_d[ConvBits-2:0], 1'b0};
        end
        cnt_d = conv_last ? '0 : cnt_q + 1'b1;
      end
      ST_LUHN: begin
        if (cnt_q == '0) begin
          len_ok_d = !too_long_q && (n16 || n15 || n13);
          cls_d    = lead_cls;
        end
        sum_d = add_mod10(sum_q, bcd_q[3:0], dbl_digit(bcd_q[7:4]));
        bcd_d = {8'd0, bcd_q[BcdW-1:8]};
        cnt_d = cnt_q + 1'b1;
      end
      default: ;
    endcase
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    conv_q     <= conv_d;
    bcd_q      <= bcd_d;
    sum_q      <= sum_d;
    too_long_q <= too_long_d;
    len_ok_q   <= len_ok_d;
    cls_q      <= cls_d;
    if (out_load) begin
      out_class_q <= (len_ok_q && sum_q == 4'd0) ? cls_q : CLASS_INVALID;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, out_class_q};

  // ---------------- assertions ----------------
`include "luhn_card_classifier_assert.svh"

  `LCC_ASSERT_NEXT(a_accept_starts_conv, in_acc, state_q == ST_CONV && cnt_q == '0)
  `LCC_ASSERT_NEXT(a_luhn_ends_in_fin, state_q == ST_LUHN && luhn_last, state_q == ST_FIN)
  `LCC_ASSERT_NEXT(a_load_sets_valid, out_load, m_axis_tvalid_o)
  `LCC_ASSERT_NOW(a_good_class_needs_checks, out_load && len_ok_q, !too_long_q)

endmodule
